### sv/i2csbe_pkg.sv
// ----------------------------------------------------------------------------
// i2csbe_pkg
// Shared types and constants for the I2C slave byte engine.
// ----------------------------------------------------------------------------
package i2csbe_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned AddrBits = 7;
  localparam int unsigned CntBits  = 4;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDR      = 3'd1,
    PH_ADDR_ACK  = 3'd2,
    PH_RX        = 3'd3,
    PH_RX_ACK    = 3'd4,
    PH_TX        = 3'd5,
    PH_MACK      = 3'd6,
    PH_WAIT_STOP = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_START   = 2'd1,
    EV_STOP    = 2'd2,
    EV_RESTART = 2'd3
  } bus_event_t;

  typedef struct packed {
    logic                scl_level;
    logic                sda_level;
    logic [ByteBits-1:0] tx_byte;
  } sample_t;

  typedef struct packed {
    logic                sda_pull_low;
    logic                rx_valid;
    logic [ByteBits-1:0] rx_byte;
    logic                tx_taken;
    bus_event_t          bus_event;
    logic                selected;
  } result_t;

endpackage

### sv/i2csbe_core.sv
// ----------------------------------------------------------------------------
// i2csbe_core
// Protocol state and one-sample update: start/stop detection, address
// match, receive shifting, transmit bit selection and acknowledge handling.
// ----------------------------------------------------------------------------
module i2csbe_core import i2csbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  sample_t             smp,
  input  logic [AddrBits-1:0] own_address,
  output result_t             res
);

  phase_t              phase_r,     phase_nxt;
  logic                prev_scl_r,  prev_scl_nxt;
  logic                prev_sda_r,  prev_sda_nxt;
  logic [CntBits-1:0]  bit_count_r, bit_count_nxt;
  logic [ByteBits-1:0] shift_in_r,  shift_in_nxt;
  logic [ByteBits-1:0] shift_out_r, shift_out_nxt;
  logic                read_mode_r, read_mode_nxt;
  logic [ByteBits-1:0] held_rx_r,   held_rx_nxt;

  logic       rise, fall, high;
  logic       rx_v, tx_t;
  bus_event_t ev;
  logic       full;

  assign rise = !prev_scl_r && smp.scl_level;
  assign fall = prev_scl_r && !smp.scl_level;
  assign high = prev_scl_r && smp.scl_level;
  assign full = (bit_count_r >= CntBits'(ByteBits));

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_in_nxt  = shift_in_r;
    shift_out_nxt = shift_out_r;
    read_mode_nxt = read_mode_r;
    held_rx_nxt   = held_rx_r;
    prev_scl_nxt  = smp.scl_level;
    prev_sda_nxt  = smp.sda_level;
    ev            = EV_NONE;
    rx_v          = 1'b0;
    tx_t          = 1'b0;

    if (high && prev_sda_r && !smp.sda_level) begin
      ev            = (phase_r == PH_IDLE) ? EV_START : EV_RESTART;
      phase_nxt     = PH_ADDR;
      bit_count_nxt = '0;
      shift_in_nxt  = '0;
    end else if (high && !prev_sda_r && smp.sda_level) begin
      ev            = EV_STOP;
      phase_nxt     = PH_IDLE;
      bit_count_nxt = '0;
    end else begin
      case (phase_r)
        PH_ADDR, PH_RX: begin
          if (rise && !full) begin
            shift_in_nxt[bit_count_r[2:0]] = shift_in_r[bit_count_r[2:0]] | smp.sda_level;
            bit_count_nxt = bit_count_r + 1'b1;
          end else if (fall && full) begin
            bit_count_nxt = '0;
            if (phase_r == PH_RX) begin
              phase_nxt = PH_RX_ACK;
            end else if (shift_in_r[AddrBits-1:0] == own_address) begin
              read_mode_nxt = shift_in_r[ByteBits-1];
              phase_nxt     = PH_ADDR_ACK;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_ADDR_ACK, PH_RX_ACK: begin
          if (rise) begin
            bit_count_nxt = CntBits'(1);
          end else if (fall && bit_count_r == CntBits'(1)) begin
            bit_count_nxt = '0;
            if (phase_r == PH_RX_ACK) begin
              held_rx_nxt  = shift_in_r;
              rx_v         = 1'b1;
              shift_in_nxt = '0;
              phase_nxt    = PH_RX;
            end else if (read_mode_r) begin
              shift_out_nxt = smp.tx_byte;
              tx_t          = 1'b1;
              phase_nxt     = PH_TX;
            end else begin
              shift_in_nxt = '0;
              phase_nxt    = PH_RX;
            end
          end
        end
        PH_TX: begin
          if (fall) begin
            if (bit_count_r + 1'b1 >= CntBits'(ByteBits)) begin
              bit_count_nxt = '0;
              phase_nxt     = PH_MACK;
            end else begin
              bit_count_nxt = bit_count_r + 1'b1;
            end
          end
        end
        PH_MACK: begin
          if (rise) begin
            if (smp.sda_level) begin
              phase_nxt = PH_WAIT_STOP;
            end else begin
              bit_count_nxt = CntBits'(1);
            end
          end else if (fall && bit_count_r == CntBits'(1)) begin
            bit_count_nxt = '0;
            shift_out_nxt = smp.tx_byte;
            tx_t          = 1'b1;
            phase_nxt     = PH_TX;
          end
        end
        default: begin
        end
      endcase
    end

    res.rx_valid  = rx_v;
    res.rx_byte   = held_rx_nxt;
    res.tx_taken  = tx_t;
    res.bus_event = ev;
    res.selected  = (phase_nxt == PH_ADDR_ACK) || (phase_nxt == PH_RX) ||
                    (phase_nxt == PH_RX_ACK) || (phase_nxt == PH_TX) ||
                    (phase_nxt == PH_MACK) || (phase_nxt == PH_WAIT_STOP);
    if (phase_nxt == PH_ADDR_ACK || phase_nxt == PH_RX_ACK) begin
      res.sda_pull_low = 1'b1;
    end else if (phase_nxt == PH_TX && bit_count_nxt < CntBits'(ByteBits)) begin
      res.sda_pull_low = !shift_out_nxt[bit_count_nxt[2:0]];
    end else begin
      res.sda_pull_low = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      prev_scl_r  <= 1'b1;
      prev_sda_r  <= 1'b1;
      bit_count_r <= '0;
      shift_in_r  <= '0;
      shift_out_r <= '0;
      read_mode_r <= 1'b0;
      held_rx_r   <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      prev_scl_r  <= prev_scl_nxt;
      prev_sda_r  <= prev_sda_nxt;
      bit_count_r <= bit_count_nxt;
      shift_in_r  <= shift_in_nxt;
      shift_out_r <= shift_out_nxt;
      read_mode_r <= read_mode_nxt;
      held_rx_r   <= held_rx_nxt;
    end
  end

endmodule

### sv/i2c_slave_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_slave_byte_engine_unit
// Seven-bit-address I2C slave working on one SCL/SDA sample per transfer.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | scl_level, sda_level, tx_byte
//   out     | output    | out_valid / out_ready | pull, rx, tx_taken, event, sel
//   cfg     | input     | cfg_wr_en             | own_address (7 bits)
//
// One sample per cycle sustained while the result is not stalled.
// Samples land in an input register; the protocol state updates when that
// sample moves into the result register.
// A stalled result holds both registers; in_ready drops only when both full.
// Synchronous active-low reset; own_address resets to 1.
// ----------------------------------------------------------------------------
module i2c_slave_byte_engine_unit import i2csbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_scl_level,
  input  logic                in_sda_level,
  input  logic [ByteBits-1:0] in_tx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_sda_pull_low,
  output logic                out_rx_valid,
  output logic [ByteBits-1:0] out_rx_byte,
  output logic                out_tx_taken,
  output logic [1:0]          out_bus_event,
  output logic                out_selected,
  input  logic                cfg_wr_en,
  input  logic [AddrBits-1:0] cfg_wr_data
);

  logic [AddrBits-1:0] own_address_r;
  logic                smp_valid_r;
  sample_t             smp_r;
  logic                res_valid_r;
  result_t             res_r;
  result_t             res;
  logic                advance;

  assign advance  = smp_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !smp_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= AddrBits'(1);
    end else if (cfg_wr_en) begin
      own_address_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        smp_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r.scl_level <= in_scl_level;
      smp_r.sda_level <= in_sda_level;
      smp_r.tx_byte   <= in_tx_byte;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  i2csbe_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .smp         (smp_r),
    .own_address (own_address_r),
    .res         (res)
  );

  assign out_valid        = res_valid_r;
  assign out_sda_pull_low = res_r.sda_pull_low;
  assign out_rx_valid     = res_r.rx_valid;
  assign out_rx_byte      = res_r.rx_byte;
  assign out_tx_taken     = res_r.tx_taken;
  assign out_bus_event    = res_r.bus_event;
  assign out_selected     = res_r.selected;

endmodule

### sv/i2csbe_checker.sv
// ----------------------------------------------------------------------------
// i2csbe_checker
// Port-level checks for the I2C slave byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2csbe_checker import i2csbe_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_sda_pull_low,
  input logic                out_rx_valid,
  input logic                out_tx_taken,
  input logic [1:0]          out_bus_event,
  input logic                out_selected
);

  // stalled result must stay
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result present after reset");

  // bus event excludes byte handling in the same sample
  a_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_event != EV_NONE |-> !out_rx_valid && !out_tx_taken)
    else $error("byte handling alongside bus event");

  // stop releases the bus and deselects
  a_stop_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_event == EV_STOP |-> !out_selected && !out_sda_pull_low)
    else $error("bus held after stop");

  // received byte and transmit latch never coincide
  a_rx_tx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rx_valid && out_tx_taken))
    else $error("rx and tx in one sample");

endmodule

bind i2c_slave_byte_engine_unit i2csbe_checker u_i2csbe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sda_pull_low (out_sda_pull_low),
  .out_rx_valid     (out_rx_valid),
  .out_tx_taken     (out_tx_taken),
  .out_bus_event    (out_bus_event),
  .out_selected     (out_selected)
);
